FILE: design/sidec_pkg.sv
// ----------------------------------------------------------------------------
// sidec_pkg: shared types and constants for the signed decimal text converter
// Holds the default sizes, ASCII codes, the digit cell control word and the
// sequencer state type.
// ----------------------------------------------------------------------------
package sidec_pkg;

  // default sizes
  localparam int DEFAULT_VALUE_WIDTH = 32;
  localparam int DEFAULT_MAX_CHARS   = 11;

  // ASCII codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;

  // one BCD digit
  typedef logic [3:0] digit_t;

  // control word broadcast to every digit cell
  typedef struct packed {
    logic clear;  // zero the digit
    logic conv;   // add-3 correction and shift in one binary bit
    logic move;   // take the digit of the lower neighbor
  } cell_ctrl_t;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } state_e;

endpackage

FILE: design/sidec_digit_cell.sv
// ----------------------------------------------------------------------------
// sidec_digit_cell: one BCD digit of the conversion chain
// During conversion it applies the add-3 correction and shifts in one bit
// from the lower cell; during output it takes the lower cell's digit.
// ----------------------------------------------------------------------------
module sidec_digit_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sidec_pkg::cell_ctrl_t ctrl_i,
  input  logic                  bit_i,
  input  sidec_pkg::digit_t     digit_i,
  output logic                  bit_o,
  output sidec_pkg::digit_t     digit_o
);

  sidec_pkg::digit_t digit_q, digit_d;
  sidec_pkg::digit_t adj;

  // add 3 when the digit would overflow on the next doubling
  assign adj   = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
  assign bit_o = adj[3];

  // next digit
  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = '0;
    end else if (ctrl_i.conv) begin
      digit_d = {adj[2:0], bit_i};
    end else if (ctrl_i.move) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
    end else begin
      digit_q <= digit_d;
    end
  end

  assign digit_o = digit_q;

endmodule

FILE: design/signed_int_to_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii: signed integer to decimal ASCII text
// Converts a two's-complement value into its decimal characters, sign first,
// leading zeros suppressed, one character per output word.
// ----------------------------------------------------------------------------
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid_i, in_stall_o, value_i      | input word
//  out     | out_valid_o, out_stall_i,            | output word
//          | char_code_o, last_char_o             |
//
// An input word is accepted in an idle cycle, then runs one shift-and-add-3
// step per value bit through the row of digit cells, then drops one
// suppressed leading zero per cycle until the first digit is found, then
// emits one character per cycle while the output does not stall. Unless
// MAX_CHARS cuts the text short, zeros and digits add up to the cell count.
// in_stall_o is high from acceptance until the last character sits in the
// output register; the next word may enter while that character waits.
// Reset clears the sequencer and the output valid flag.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii #(
  parameter int VALUE_WIDTH = sidec_pkg::DEFAULT_VALUE_WIDTH,
  parameter int MAX_CHARS   = sidec_pkg::DEFAULT_MAX_CHARS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [7:0]                    char_code_o,
  output logic                          last_char_o
);

  // digits needed for the largest magnitude, 2**(VALUE_WIDTH-1)
  localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int BitCntW    = $clog2(VALUE_WIDTH);
  localparam int RemW       = $clog2(NUM_DIGITS + 1);
  localparam int CntW       = $clog2(MAX_CHARS);

  sidec_pkg::state_e state_q, state_d;

  logic [VALUE_WIDTH-1:0] mag_q, mag_d;
  logic                   neg_q, neg_d;
  logic [BitCntW-1:0]     bit_cnt_q, bit_cnt_d;
  logic [RemW-1:0]        rem_q, rem_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic                   out_valid_q, out_valid_d;
  logic [7:0]             char_q, char_d;
  logic                   last_q, last_d;

  sidec_pkg::cell_ctrl_t  ctrl;
  sidec_pkg::digit_t      digits [NUM_DIGITS];
  logic                   carry  [NUM_DIGITS+1];
  sidec_pkg::digit_t      top_digit;
  logic                   in_acc;
  logic                   out_free;
  logic                   load_out;
  logic                   at_cap;
  logic                   digit_last;

  assign in_acc    = in_valid_i && (state_q == sidec_pkg::ST_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign top_digit = digits[NUM_DIGITS-1];
  assign at_cap    = (cnt_q == CntW'(MAX_CHARS - 1));
  assign digit_last = (rem_q == RemW'(1)) || at_cap;

  // row of digit cells, least significant at index 0
  assign carry[0] = mag_q[VALUE_WIDTH-1];
  for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_cell
    sidec_digit_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .bit_i   (carry[g]),
      .digit_i ((g == 0) ? sidec_pkg::digit_t'(0) : digits[(g == 0) ? 0 : g-1]),
      .bit_o   (carry[g+1]),
      .digit_o (digits[g])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      sidec_pkg::ST_IDLE: begin
        if (in_acc) state_d = sidec_pkg::ST_CONV;
      end
      sidec_pkg::ST_CONV: begin
        if (bit_cnt_q == '0) state_d = sidec_pkg::ST_SKIP;
      end
      sidec_pkg::ST_SKIP: begin
        if (!(top_digit == '0 && rem_q > RemW'(1))) begin
          state_d = neg_q ? sidec_pkg::ST_SIGN : sidec_pkg::ST_DIGIT;
        end
      end
      sidec_pkg::ST_SIGN: begin
        if (out_free) state_d = at_cap ? sidec_pkg::ST_IDLE : sidec_pkg::ST_DIGIT;
      end
      sidec_pkg::ST_DIGIT: begin
        if (out_free && digit_last) state_d = sidec_pkg::ST_IDLE;
      end
      default: state_d = sidec_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    ctrl     = '0;
    load_out = 1'b0;
    char_d   = char_q;
    last_d   = last_q;
    unique case (state_q)
      sidec_pkg::ST_IDLE: begin
        ctrl.clear = in_acc;
      end
      sidec_pkg::ST_CONV: begin
        ctrl.conv = 1'b1;
      end
      sidec_pkg::ST_SKIP: begin
        ctrl.move = (top_digit == '0) && (rem_q > RemW'(1));
      end
      sidec_pkg::ST_SIGN: begin
        load_out = out_free;
        char_d   = out_free ? sidec_pkg::CHAR_MINUS : char_q;
        last_d   = out_free ? at_cap : last_q;
      end
      sidec_pkg::ST_DIGIT: begin
        load_out  = out_free;
        ctrl.move = out_free;
        char_d    = out_free ? sidec_pkg::CHAR_ZERO + {4'd0, top_digit} : char_q;
        last_d    = out_free ? digit_last : last_q;
      end
      default: ;
    endcase
  end

  // datapath and counters
  always_comb begin
    mag_d     = mag_q;
    neg_d     = neg_q;
    bit_cnt_d = bit_cnt_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    if (in_acc) begin
      neg_d     = value_i[VALUE_WIDTH-1];
      mag_d     = value_i[VALUE_WIDTH-1] ? (~value_i + 1'b1) : value_i;
      bit_cnt_d = BitCntW'(VALUE_WIDTH - 1);
      rem_d     = RemW'(NUM_DIGITS);
      cnt_d     = '0;
    end else if (ctrl.conv) begin
      mag_d     = {mag_q[VALUE_WIDTH-2:0], 1'b0};
      bit_cnt_d = bit_cnt_q - BitCntW'(1);
    end
    if (ctrl.move) rem_d = rem_q - RemW'(1);
    if (load_out)  cnt_d = cnt_q + CntW'(1);
  end

  // output register valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sidec_pkg::ST_IDLE;
      neg_q       <= 1'b0;
      bit_cnt_q   <= '0;
      rem_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      neg_q       <= neg_d;
      bit_cnt_q   <= bit_cnt_d;
      rem_q       <= rem_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    char_q <= char_d;
    last_q <= last_d;
  end

  assign in_stall_o  = (state_q != sidec_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign char_code_o = char_q;
  assign last_char_o = last_q;

endmodule

FILE: tb/signed_int_to_decimal_ascii_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_test: self-checking bench for the decimal printer
// Sends signed 32-bit words, predicts the ASCII text of each (sign, digits
// without leading zeros, last flag on the final character) and checks every
// output word in order, under random idling and a long output hold-off.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_test;

  localparam int VW           = sidec_pkg::DEFAULT_VALUE_WIDTH;
  localparam int MC           = sidec_pkg::DEFAULT_MAX_CHARS;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 80;
  localparam int LIMIT_CYCLES = 1_000_000;
  localparam int MAX_REPORTS  = 100;

  typedef struct packed {
    logic [7:0] code;
    logic       is_last;
  } char_word_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  logic signed [VW-1:0] value_i     = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [7:0]           char_code_o;
  logic                 last_char_o;

  char_word_t expected_chars_q[$];
  int         error_count   = 0;
  int         cycle_count   = 0;
  bit         idle_on       = 1'b0;
  int         hold_requests = 0;
  int         hold_served   = 0;

  signed_int_to_decimal_ascii u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .value_i     (value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .char_code_o (char_code_o),
    .last_char_o (last_char_o)
  );

  // clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("signed_int_to_decimal_ascii_test: done, errors");
      $finish;
    end
  end

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // text of one value: optional minus, digits most significant first
  function automatic void predict_text(input logic [VW-1:0] raw);
    logic       neg;
    logic [VW-1:0] mag;
    logic [7:0] text_q[$];
    int         n_chars;
    neg = raw[VW-1];
    // most negative value: two's complement of it is the top bit, still unsigned
    mag = neg ? (~raw + 1'b1) : raw;
    do begin
      text_q.push_front(sidec_pkg::CHAR_ZERO + 8'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (neg) text_q.push_front(sidec_pkg::CHAR_MINUS);
    n_chars = (text_q.size() > MC) ? MC : text_q.size();
    for (int k = 0; k < n_chars; k++)
      expected_chars_q.push_back(char_word_t'{code: text_q[k],
                                              is_last: (k == n_chars - 1)});
  endfunction

  // random value spread over every magnitude and both extremes
  function automatic logic [VW-1:0] rand_value();
    logic [VW-1:0] v;
    int            r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      v = $urandom;
    end else if (r < 60) begin
      v = VW'($urandom_range(0, 2000)) - VW'(1000);
    end else if (r < 85) begin
      v = $urandom >> $urandom_range(0, VW - 1);
      if ($urandom_range(0, 1)) v = ~v + 1'b1;
    end else if (r < 93) begin
      v = {1'b0, {(VW-1){1'b1}}} - VW'($urandom_range(0, 20));
    end else begin
      v = {1'b1, {(VW-1){1'b0}}} + VW'($urandom_range(0, 20));
    end
    return v;
  endfunction

  // send one input word and queue its text at acceptance
  task automatic send_value(input logic [VW-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    value_i    <= v;
    do @(posedge clk_i); while (in_stall_o);
    predict_text(v);
  endtask

  // receiver stall pattern, with a long hold-off on request
  initial begin
    int n;
    @(posedge clk_i);
    forever begin
      if (hold_served != hold_requests) begin
        hold_served++;
        out_stall_i <= 1'b1;
        n = HOLD_CYCLES;
      end else begin
        n = pick_gap();
        out_stall_i <= (n != 0);
        if (n == 0) n = $urandom_range(1, 8);
      end
      repeat (n) @(posedge clk_i);
    end
  end

  // compare each output word with the oldest expected character
  always @(posedge clk_i) begin : check_words
    char_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_chars_q.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: unexpected word, expected none, actual char %h last %b",
                   $time, char_code_o, last_char_o);
      end else begin
        want = expected_chars_q.pop_front();
        if (char_code_o !== want.code) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: char_code expected %h actual %h", $time, want.code, char_code_o);
        end
        if (last_char_o !== want.is_last) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: last_char expected %b actual %b", $time, want.is_last,
                     last_char_o);
        end
      end
    end
  end

  // zero, single digits, digit count boundaries and both extremes
  task automatic test_directed_values();
    logic [VW-1:0] dir_vals[$];
    dir_vals = '{0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 123456789, -5,
                 999999999, -999999999, 1000000000, -1000000000,
                 {1'b0, {(VW-1){1'b1}}}, {1'b1, {(VW-1){1'b0}}},
                 {1'b1, {(VW-2){1'b0}}, 1'b1}, {VW{1'b0}} | 32'h5555_5555,
                 32'hAAAA_AAAA};
    idle_on = 1'b0;
    foreach (dir_vals[i]) send_value(dir_vals[i]);
  endtask

  // random words under random idling on both sides
  task automatic test_random_values(input int count);
    idle_on = 1'b1;
    repeat (count) send_value(rand_value());
  endtask

  // output held off for a long stretch while input words keep coming
  task automatic test_output_hold();
    idle_on = 1'b0;
    hold_requests++;
    repeat (24) send_value(rand_value());
  endtask

  // back to back words with no idling
  task automatic test_back_to_back();
    idle_on = 1'b0;
    repeat (20) send_value(rand_value());
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_values();
    test_random_values(100);
    test_output_hold();
    test_random_values(95);
    test_back_to_back();

    in_valid_i <= 1'b0;
    while (expected_chars_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (expected_chars_q.size() != 0) begin
      error_count++;
      $display("%0t: %0d expected words never arrived", $time, expected_chars_q.size());
    end

    if (error_count == 0) begin
      $display("signed_int_to_decimal_ascii_test: done, clean");
    end else begin
      $display("signed_int_to_decimal_ascii_test: done, errors");
    end
    $finish;
  end

endmodule
